FILE: rtl/lsw_pkg.sv
package lsw_pkg;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] RK_WRITE_BACK = 2'd0;
  localparam logic [1:0] RK_READ       = 2'd1;
  localparam logic [1:0] RK_WRITE_DONE = 2'd2;

  localparam logic       CFG_CAPACITY = 1'b0;
  localparam logic       CFG_SPP      = 1'b1;

  localparam logic [10:0] CAP_RESET = 11'd1024;
  localparam logic [5:0]  SPP_RESET = 6'd4;

  // classified request handed from the front to the back
  typedef struct packed {
    logic        cmd;
    logic [31:0] page;
    logic [31:0] acc;
    logic [31:0] full;
    logic [5:0]  spp;
    logic [5:0]  cnt;
  } item_t;

  function automatic logic [5:0] popcount(input logic [31:0] v);
    logic [5:0] c;
    c = '0;
    for (int k = 0; k < 32; k++) c = c + {5'b0, v[k]};
    return c;
  endfunction

endpackage

FILE: rtl/lsw_front.sv
module lsw_front #(
  parameter int MAX_SPP = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [31:0]        in_page_number,
  input  logic [31:0]        in_sector_mask,
  input  logic [5:0]         spp_cfg,
  output logic               q_valid,
  output lsw_pkg::item_t     q_item,
  input  logic               q_pop
);
  import lsw_pkg::*;

  localparam logic [5:0] MAXS = 6'(MAX_SPP);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic [5:0] spp;
  logic [31:0] full;
  item_t      cls;
  logic       push;

  // clamp the page width and mask the access to it
  always_comb begin
    spp = spp_cfg;
    if (spp == 6'd0) spp = 6'd1;
    if (spp > MAXS) spp = MAXS;
    full = ~(32'hffffffff << spp);
    cls.cmd  = in_command;
    cls.page = in_page_number;
    cls.acc  = in_sector_mask & full;
    cls.full = full;
    cls.spp  = spp;
    cls.cnt  = popcount(in_sector_mask & full);
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = ~wr_ptr_r;
    if (q_pop && q_valid) rd_ptr_nxt = ~rd_ptr_r;
    if (push && !(q_pop && q_valid)) count_nxt = count_r + 2'd1;
    else if (!push && q_pop && q_valid) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/lsw_engine.sv
module lsw_engine #(
  parameter int ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lsw_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic [10:0]        cap,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [31:0]        out_result_page,
  output logic [31:0]        out_result_mask,
  output logic [31:0]        out_hit_mask,
  output logic [5:0]         out_nsectors,
  output logic               out_last
);
  import lsw_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic [4:0] S_IDLE = 5'd0,  S_LRD = 5'd1,   S_LCHK = 5'd2,  S_DISP = 5'd3,
                         S_MTH_RD = 5'd4, S_MTH_UL = 5'd5, S_PA = 5'd6,  S_PB = 5'd7,
                         S_EV_RD = 5'd8, S_EV_OUT = 5'd9, S_MEV = 5'd10, S_ALLOC = 5'd11,
                         S_ALLOC_POP = 5'd12, S_INS = 5'd13, S_HBIT = 5'd14,
                         S_HVIC = 5'd15, S_HVIC2 = 5'd16, S_HADD = 5'd17, S_FIN = 5'd18;

  logic [31:0]   tag_mem  [ENTRIES];
  logic [31:0]   st_mem   [ENTRIES];
  logic [PW-1:0] prev_mem [ENTRIES];
  logic [PW-1:0] next_mem [ENTRIES];
  logic [AW-1:0] free_mem [ENTRIES];
  logic [31:0]   tag_q, st_q;
  logic [PW-1:0] prev_q, next_q;
  logic [AW-1:0] free_q;

  logic [4:0]    state_r, state_nxt, ret_r, ret_nxt;
  item_t         item_r, item_nxt;
  logic [PW-1:0] cur_r, cur_nxt, node_r, node_nxt, vic_r, vic_nxt, ins_r, ins_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, sp_r, sp_nxt, fill_r, fill_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   nst_r, nst_nxt, hit_r, hit_nxt;
  logic signed [6:0] need_r, need_nxt;
  logic [5:0]    bi_r, bi_nxt;
  logic [10:0]   used_r, used_nxt, fr;

  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic [31:0]   op_r, op_nxt, om_r, om_nxt, oh_r, oh_nxt;
  logic [5:0]    oc_r, oc_nxt, ev_cnt;
  logic          out_free;

  logic          rd_en, free_rd_en;
  logic [AW-1:0] rd_addr, free_rd_addr;
  logic          tag_we, st_we, prev_we, next_we, free_we;
  logic [AW-1:0] tag_addr, st_addr, prev_addr, next_addr, free_addr;
  logic [31:0]   tag_data, st_data;
  logic [PW-1:0] prev_data, next_data;
  logic [AW-1:0] free_data;
  logic          ul_go;
  logic [PW-1:0] ul_i, ul_p, ul_nx;
  logic [31:0]   bit_m;

  assign out_free = !ov_r || !out_stall;
  assign ev_cnt   = popcount(st_q);
  assign bit_m    = 32'h1 << bi_r[4:0];
  assign fr       = (used_r >= cap) ? 11'd0 : cap - used_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;    item_nxt = item_r;
    cur_nxt = cur_r;      node_nxt = node_r;  vic_nxt = vic_r;   ins_nxt = ins_r;
    head_nxt = head_r;    tail_nxt = tail_r;  sp_nxt = sp_r;     fill_nxt = fill_r;
    found_nxt = found_r;  nst_nxt = nst_r;    hit_nxt = hit_r;   need_nxt = need_r;
    bi_nxt = bi_r;        used_nxt = used_r;
    ov_nxt = ov_r && out_stall;
    ok_nxt = ok_r; op_nxt = op_r; om_nxt = om_r; oh_nxt = oh_r; oc_nxt = oc_r; ol_nxt = ol_r;
    q_pop = 1'b0;
    rd_en = 1'b0;      rd_addr = cur_r[AW-1:0];
    free_rd_en = 1'b0; free_rd_addr = '0;
    tag_we = 1'b0;  tag_addr = ins_r[AW-1:0];  tag_data = item_r.page;
    st_we = 1'b0;   st_addr = ins_r[AW-1:0];   st_data = item_r.acc;
    prev_we = 1'b0; prev_addr = '0;            prev_data = NIL;
    next_we = 1'b0; next_addr = '0;            next_data = NIL;
    free_we = 1'b0; free_addr = sp_r[AW-1:0];  free_data = vic_r[AW-1:0];
    ul_go = 1'b0; ul_i = node_r; ul_p = prev_q; ul_nx = next_q;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          item_nxt = q_item;
          cur_nxt = head_r;
          state_nxt = S_LRD;
        end
      end
      // walk the list from the head looking for the tag
      S_LRD: begin
        if (cur_r == NIL) begin
          found_nxt = 1'b0;
          state_nxt = S_DISP;
        end else begin
          rd_en = 1'b1;
          rd_addr = cur_r[AW-1:0];
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (tag_q == item_r.page) begin
          found_nxt = 1'b1;
          node_nxt = cur_r;
          nst_nxt = st_q;
          state_nxt = S_DISP;
        end else begin
          cur_nxt = next_q;
          state_nxt = S_LRD;
        end
      end
      S_DISP: begin
        if (item_r.cmd == CMD_READ) begin
          hit_nxt = found_r ? (nst_r & item_r.acc) : 32'h0;
          if (found_r && ((nst_r & item_r.acc) != 32'h0)) begin
            ret_nxt = S_FIN;
            state_nxt = S_MTH_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (!found_r) begin
          hit_nxt = 32'h0;
          if (item_r.acc == 32'h0) begin
            state_nxt = S_FIN;
          end else begin
            if ({5'b0, item_r.cnt} > fr)
              need_nxt = $signed({1'b0, item_r.cnt} - {1'b0, fr[5:0]});
            else
              need_nxt = 7'sd0;
            state_nxt = S_MEV;
          end
        end else begin
          hit_nxt = nst_r & item_r.acc;
          bi_nxt = 6'd0;
          state_nxt = S_HBIT;
        end
      end
      // move node to head
      S_MTH_RD: begin
        if (head_r == node_r) begin
          state_nxt = ret_r;
        end else begin
          rd_en = 1'b1;
          rd_addr = node_r[AW-1:0];
          state_nxt = S_MTH_UL;
        end
      end
      S_MTH_UL: begin
        ul_go = 1'b1;
        ins_nxt = node_r;
        state_nxt = S_PA;
      end
      S_PA: begin
        prev_we = 1'b1; prev_addr = ins_r[AW-1:0]; prev_data = NIL;
        next_we = 1'b1; next_addr = ins_r[AW-1:0]; next_data = head_r;
        state_nxt = S_PB;
      end
      S_PB: begin
        if (head_r != NIL) begin
          prev_we = 1'b1; prev_addr = head_r[AW-1:0]; prev_data = ins_r;
        end else begin
          tail_nxt = ins_r;
        end
        head_nxt = ins_r;
        state_nxt = ret_r;
      end
      // evict vic_r: report it, unlink it, free its slot
      S_EV_RD: begin
        rd_en = 1'b1;
        rd_addr = vic_r[AW-1:0];
        state_nxt = S_EV_OUT;
      end
      S_EV_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = RK_WRITE_BACK; op_nxt = tag_q; om_nxt = st_q;
          oh_nxt = 32'h0; oc_nxt = ev_cnt; ol_nxt = 1'b0;
          used_nxt = (used_r >= {5'b0, ev_cnt}) ? used_r - {5'b0, ev_cnt} : 11'd0;
          need_nxt = need_r - $signed({1'b0, ev_cnt});
          ul_go = 1'b1; ul_i = vic_r;
          free_we = 1'b1;
          sp_nxt = sp_r + PW'(1);
          state_nxt = ret_r;
        end
      end
      S_MEV: begin
        if (need_r > 7'sd0 && tail_r != NIL) begin
          vic_nxt = tail_r;
          ret_nxt = S_MEV;
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (fill_r == NIL && sp_r == '0) begin
          vic_nxt = tail_r;
          ret_nxt = S_ALLOC;
          state_nxt = S_EV_RD;
        end else if (sp_r != '0) begin
          free_rd_en = 1'b1;
          free_rd_addr = AW'(sp_r - PW'(1));
          sp_nxt = sp_r - PW'(1);
          state_nxt = S_ALLOC_POP;
        end else begin
          ins_nxt = fill_r;
          fill_nxt = fill_r + PW'(1);
          state_nxt = S_INS;
        end
      end
      S_ALLOC_POP: begin
        ins_nxt = {1'b0, free_q};
        state_nxt = S_INS;
      end
      S_INS: begin
        tag_we = 1'b1;
        st_we = 1'b1;
        prev_we = 1'b1; prev_addr = ins_r[AW-1:0]; prev_data = NIL;
        next_we = 1'b1; next_addr = ins_r[AW-1:0]; next_data = head_r;
        used_nxt = used_r + {5'b0, item_r.cnt};
        ret_nxt = S_FIN;
        state_nxt = S_PB;
      end
      // write hit: one sector per pass
      S_HBIT: begin
        if (bi_r >= item_r.spp) begin
          state_nxt = S_FIN;
        end else if (!item_r.acc[bi_r[4:0]]) begin
          bi_nxt = bi_r + 6'd1;
        end else if (nst_r[bi_r[4:0]]) begin
          bi_nxt = bi_r + 6'd1;
          ret_nxt = S_HBIT;
          state_nxt = S_MTH_RD;
        end else if (used_r >= cap) begin
          state_nxt = S_HVIC;
        end else begin
          state_nxt = S_HADD;
        end
      end
      S_HVIC: begin
        if (tail_r != node_r) begin
          vic_nxt = tail_r;
          ret_nxt = S_HADD;
          state_nxt = S_EV_RD;
        end else if (head_r == node_r) begin
          state_nxt = S_HADD;
        end else begin
          rd_en = 1'b1;
          rd_addr = node_r[AW-1:0];
          state_nxt = S_HVIC2;
        end
      end
      S_HVIC2: begin
        vic_nxt = prev_q;
        ret_nxt = S_HADD;
        state_nxt = S_EV_RD;
      end
      S_HADD: begin
        st_we = 1'b1; st_addr = node_r[AW-1:0]; st_data = nst_r | bit_m;
        nst_nxt = nst_r | bit_m;
        used_nxt = used_r + 11'd1;
        bi_nxt = bi_r + 6'd1;
        ret_nxt = S_HBIT;
        state_nxt = S_MTH_RD;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt = 1'b1; op_nxt = item_r.page; oh_nxt = hit_r;
          oc_nxt = popcount(hit_r); ol_nxt = 1'b1;
          if (item_r.cmd == CMD_READ) begin
            ok_nxt = RK_READ;
            om_nxt = item_r.full & ~hit_r;
          end else begin
            ok_nxt = RK_WRITE_DONE;
            om_nxt = 32'h0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // unlink ul_i given its neighbors
    if (ul_go) begin
      if (head_r == ul_i) head_nxt = ul_nx;
      else if (ul_p != NIL) begin
        next_we = 1'b1; next_addr = ul_p[AW-1:0]; next_data = ul_nx;
      end
      if (tail_r == ul_i) tail_nxt = ul_p;
      else if (ul_nx != NIL) begin
        prev_we = 1'b1; prev_addr = ul_nx[AW-1:0]; prev_data = ul_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_addr] <= tag_data;
    if (rd_en) tag_q <= tag_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_addr] <= st_data;
    if (rd_en) st_q <= st_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_addr] <= prev_data;
    if (rd_en) prev_q <= prev_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_addr] <= next_data;
    if (rd_en) next_q <= next_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_addr] <= free_data;
    if (free_rd_en) free_q <= free_mem[free_rd_addr];
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; cur_r <= cur_nxt; node_r <= node_nxt; vic_r <= vic_nxt;
    ins_r <= ins_nxt; found_r <= found_nxt; nst_r <= nst_nxt; hit_r <= hit_nxt;
    need_r <= need_nxt; bi_r <= bi_nxt; ret_r <= ret_nxt;
    ok_r <= ok_nxt; op_r <= op_nxt; om_r <= om_nxt; oh_r <= oh_nxt; oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NIL;
      tail_r  <= NIL;
      sp_r    <= '0;
      fill_r  <= '0;
      used_r  <= 11'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      sp_r    <= sp_nxt;
      fill_r  <= fill_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = ok_r;
  assign out_result_page  = op_r;
  assign out_result_mask  = om_r;
  assign out_hit_mask     = oh_r;
  assign out_nsectors     = oc_r;
  assign out_last         = ol_r;

endmodule

FILE: rtl/lru_sector_write_buffer_top.sv
// LRU sector write buffer.
// Input channel (in_valid / in_stall): one page access request per handshake,
// a read or write of the sectors in in_sector_mask of page in_page_number.
// Output channel (out_valid / out_stall): zero or more write-back results for
// evicted pages, then exactly one read response or write done with out_last set.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 capacity in
// sectors, index 1 sectors per page; write only while the block is idle.
// A front stage classifies each request into a two-entry queue; the back
// engine walks the LRU linked list in memory for the tag lookup, reading
// then checking each entry visited, then updates the list, reports each
// eviction once the output register is free, and on a write hit steps
// through the sector slots one per pass.
// Reset (rst_n low, synchronous) empties the list and the free-slot counters
// at once: no clearing pass is needed. A stalled receiver holds the output
// register; the engine waits, and the queue takes requests until full.
module lru_sector_write_buffer_top #(
  parameter int ENTRIES = 1024,
  parameter int MAX_SECTORS_PER_PAGE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_page_number,
  input  logic [31:0] in_sector_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_result_page,
  output logic [31:0] out_result_mask,
  output logic [31:0] out_hit_mask,
  output logic [5:0]  out_nsectors,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import lsw_pkg::*;

  logic [10:0] cap_r, cap_nxt;
  logic [5:0]  spp_r, spp_nxt;
  logic        q_valid, q_pop;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  // take configuration writes; anything else holds
  always_comb begin
    cap_nxt = cap_r;
    spp_nxt = spp_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPACITY: cap_nxt = cfg_data;
        CFG_SPP:      spp_nxt = cfg_data[5:0];
        default:      cap_nxt = cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      spp_r <= SPP_RESET;
    end else begin
      cap_r <= cap_nxt;
      spp_r <= spp_nxt;
    end
  end

  // front: classify and queue requests
  lsw_front #(.MAX_SPP(MAX_SECTORS_PER_PAGE)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_page_number (in_page_number),
    .in_sector_mask (in_sector_mask),
    .spp_cfg        (spp_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // back: lookup, evict, insert and report
  lsw_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .cap              (cap_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_page  (out_result_page),
    .out_result_mask  (out_result_mask),
    .out_hit_mask     (out_hit_mask),
    .out_nsectors     (out_nsectors),
    .out_last         (out_last)
  );

endmodule

FILE: dv/lru_sector_write_buffer_top_tb.sv
`timescale 1ns / 100ps

module lru_sector_write_buffer_top_tb;
  import lsw_pkg::*;

  localparam int NSLOT = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] page;
    logic [31:0] mask;
    logic [31:0] hit;
    logic [5:0]  cnt;
    logic        last;
  } buf_result_t;

  // Shadow of the page buffer: LRU list, sector masks and the results each
  // request must produce, oldest first.
  class sector_buffer_model;
    bit          slot_valid[NSLOT];
    logic [31:0] slot_tag[NSLOT];
    logic [31:0] slot_stored[NSLOT];
    int          prv[NSLOT];
    int          nxt[NSLOT];
    int          head, tail, used;
    int          capacity, page_width;
    int          mismatches, results_seen;
    buf_result_t pending_results[$];

    function new();
      foreach (slot_valid[k]) slot_valid[k] = 0;
      head = -1;
      tail = -1;
      used = 0;
      capacity = CAP_RESET;
      page_width = SPP_RESET;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic idx, logic [10:0] d);
      if (idx == CFG_CAPACITY) capacity = d;
      else page_width = d[5:0];
    endfunction

    function void push(logic [1:0] k, logic [31:0] pg, logic [31:0] m, logic [31:0] h,
                       int c, logic l);
      buf_result_t r;
      r.kind = k; r.page = pg; r.mask = m; r.hit = h; r.cnt = c[5:0]; r.last = l;
      pending_results.push_back(r);
    endfunction

    function void unlink(int i);
      int p, n;
      p = prv[i];
      n = nxt[i];
      if (head == i) head = n; else if (p >= 0) nxt[p] = n;
      if (tail == i) tail = p; else if (n >= 0) prv[n] = p;
    endfunction

    function void to_front(int i);
      prv[i] = -1;
      nxt[i] = head;
      if (head >= 0) prv[head] = i; else tail = i;
      head = i;
    endfunction

    function void promote(int i);
      if (head != i) begin
        unlink(i);
        to_front(i);
      end
    endfunction

    function int write_back(int i);
      int c;
      c = $countones(slot_stored[i]);
      push(RK_WRITE_BACK, slot_tag[i], slot_stored[i], '0, c, 1'b0);
      used = (used >= c) ? used - c : 0;
      unlink(i);
      slot_valid[i] = 0;
      return c;
    endfunction

    function void note_access(logic cmd, logic [31:0] pg, logic [31:0] msk);
      int w, node, slot, c, fr, need, victim;
      logic [31:0] full, acc, hit, bitm;
      w = (page_width < 1) ? 1 : (page_width > 32 ? 32 : page_width);
      full = (w >= 32) ? 32'hffffffff : ((32'd1 << w) - 1);
      acc = msk & full;
      node = -1;
      for (int k = 0; k < NSLOT; k++)
        if (slot_valid[k] && slot_tag[k] == pg) begin
          node = k;
          break;
        end
      if (cmd == CMD_READ) begin
        hit = (node >= 0) ? (slot_stored[node] & acc) : '0;
        if (hit != 0) promote(node);
        push(RK_READ, pg, full & ~hit, hit, $countones(hit), 1'b1);
        return;
      end
      hit = '0;
      if (node < 0) begin
        if (acc != 0) begin
          c = $countones(acc);
          fr = (used >= capacity) ? 0 : capacity - used;
          if (c > fr) begin
            need = c - fr;
            while (need > 0 && tail >= 0) need -= write_back(tail);
          end
          slot = -1;
          for (int k = 0; k < NSLOT; k++)
            if (!slot_valid[k]) begin
              slot = k;
              break;
            end
          if (slot < 0) begin
            slot = tail;
            void'(write_back(slot));
          end
          slot_valid[slot] = 1;
          slot_tag[slot] = pg;
          slot_stored[slot] = acc;
          to_front(slot);
          used += c;
        end
      end else begin
        hit = slot_stored[node] & acc;
        for (int k = 0; k < w; k++) begin
          bitm = 32'd1 << k;
          if ((acc & bitm) == 0) continue;
          if ((slot_stored[node] & bitm) != 0) begin
            promote(node);
            continue;
          end
          if (used >= capacity) begin
            victim = tail;
            if (victim == node) victim = (head != node) ? prv[node] : -1;
            if (victim >= 0) void'(write_back(victim));
          end
          promote(node);
          slot_stored[node] |= bitm;
          used++;
        end
      end
      push(RK_WRITE_DONE, pg, '0, hit, $countones(hit), 1'b1);
    endfunction

    function void check_result(buf_result_t got);
      buf_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d page %h", got.kind, got.page);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind exp %0d got %0d", want.kind, got.kind); mismatches++;
      end
      if (got.page !== want.page) begin
        $error("result_page exp %h got %h", want.page, got.page); mismatches++;
      end
      if (got.mask !== want.mask) begin
        $error("result_mask exp %h got %h", want.mask, got.mask); mismatches++;
      end
      if (got.hit !== want.hit) begin
        $error("hit_mask exp %h got %h", want.hit, got.hit); mismatches++;
      end
      if (got.cnt !== want.cnt) begin
        $error("nsectors exp %0d got %0d", want.cnt, got.cnt); mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last exp %0d got %0d", want.last, got.last); mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall, in_command;
  logic [31:0] in_page_number, in_sector_mask;
  logic        out_valid, out_stall;
  logic [1:0]  out_result_kind;
  logic [31:0] out_result_page, out_result_mask, out_hit_mask;
  logic [5:0]  out_nsectors;
  logic        out_last;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [10:0] cfg_data;

  sector_buffer_model buf_model;
  int          cycles;
  int          requests_sent;
  int          stall_left;
  bit          stall_enable;
  bit          gap_enable;
  logic [31:0] page_pool[12];

  lru_sector_write_buffer_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_page_number(in_page_number), .in_sector_mask(in_sector_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_result_page(out_result_page),
    .out_result_mask(out_result_mask), .out_hit_mask(out_hit_mask),
    .out_nsectors(out_nsectors), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next stall.
  // Mostly short stalls, now and then a long one, none when disabled.
  always @(posedge clk) begin
    buf_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.kind = out_result_kind; r.page = out_result_page; r.mask = out_result_mask;
      r.hit = out_hit_mask; r.cnt = out_nsectors; r.last = out_last;
      buf_model.check_result(r);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_enable && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gap_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one request, hold it until accepted, then drop valid for any gap picked.
  task automatic send_access(logic cmd, logic [31:0] pg, logic [31:0] msk);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_page_number <= pg;
    in_sector_mask <= msk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    buf_model.note_access(cmd, pg, msk);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has come back, plus some margin.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (buf_model.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register writes only happen with the block drained; the caller drops
  // cfg_valid after the last write.
  task automatic write_reg(logic idx, logic [10:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    buf_model.set_reg(idx, d);
  endtask

  task automatic setup_phase(logic [10:0] cap, logic [10:0] spp);
    drain();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_SPP, spp);
    cfg_valid <= 1'b0;
    foreach (page_pool[k]) page_pool[k] = $urandom;
    stall_enable = $urandom_range(0, 3) != 0;
    gap_enable = $urandom_range(0, 3) != 0;
  endtask

  // Mostly pooled pages so hits and evictions happen; some random noise.
  task automatic random_run(int count, int pool_size, bit pause_midway);
    logic [31:0] pg, msk;
    logic        cmd;
    int          r;
    for (int k = 0; k < count; k++) begin
      pg = ($urandom_range(0, 99) < 8) ? $urandom : page_pool[$urandom_range(0, pool_size - 1)];
      cmd = ($urandom_range(0, 99) < 60) ? CMD_WRITE : CMD_READ;
      r = $urandom_range(0, 99);
      if (r < 35) msk = $urandom;
      else if (r < 65) msk = 32'd1 << $urandom_range(0, 31);
      else msk = $urandom & $urandom & $urandom;
      if (msk == 0) msk = 32'h1;
      send_access(cmd, pg, msk);
      if (pause_midway && k == count / 2) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_READ;
    in_page_number = '0;
    in_sector_mask = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_data = '0;
    cycles = 0;
    requests_sent = 0;
    stall_left = 0;
    stall_enable = 1'b0;
    gap_enable = 1'b0;
    buf_model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: read of an empty buffer, extreme pages, hits, mask
    // bits beyond the page width, and a write that is empty within the page.
    send_access(CMD_READ, 32'h0, 32'hffffffff);
    send_access(CMD_WRITE, 32'h0, 32'h00000001);
    send_access(CMD_WRITE, 32'hffffffff, 32'hffffffff);
    send_access(CMD_READ, 32'hffffffff, 32'h80000000);
    send_access(CMD_READ, 32'h0, 32'h0000000f);
    send_access(CMD_WRITE, 32'h0, 32'h0000000e);
    send_access(CMD_WRITE, 32'h12345678, 32'hfffffff0);
    send_access(CMD_READ, 32'h12345678, 32'h00000001);

    // Tiny capacity: sole entry grows past capacity, then the hit page sits
    // at the tail and its neighbor goes instead.
    setup_phase(11'd2, 11'd4);
    send_access(CMD_WRITE, 32'hA, 32'h3);
    send_access(CMD_WRITE, 32'hA, 32'hC);
    send_access(CMD_WRITE, 32'hB, 32'h1);
    send_access(CMD_WRITE, 32'hC, 32'h1);
    send_access(CMD_WRITE, 32'hB, 32'h2);
    send_access(CMD_READ, 32'hC, 32'hf);

    // Page wider than capacity: evict everything, insert anyway.
    setup_phase(11'd2, 11'd8);
    send_access(CMD_WRITE, 32'h55, 32'hff);
    send_access(CMD_WRITE, 32'h66, 32'h01);
    // Lower capacity below current use: free space reads as zero.
    setup_phase(11'd0, 11'd0);
    send_access(CMD_WRITE, 32'h77, 32'h3);
    send_access(CMD_WRITE, 32'h66, 32'h1);
    setup_phase(11'd2047, 11'd63);
    send_access(CMD_WRITE, 32'h88, 32'hffffffff);
    send_access(CMD_READ, 32'h88, 32'h80000001);

    // Random phases across a spread of capacities and page widths.
    setup_phase(11'd2, 11'd1);
    random_run(50, 4, 1'b0);
    setup_phase(11'd16, 11'd8);
    random_run(70, 12, 1'b1);
    setup_phase(11'd64, 11'd32);
    random_run(60, 12, 1'b0);
    setup_phase(11'd1, 11'd3);
    random_run(40, 6, 1'b0);
    setup_phase(11'd40, 11'd16);
    random_run(60, 10, 1'b0);
    setup_phase(11'd1024, 11'd4);
    random_run(30, 12, 1'b0);
    setup_phase(11'd2047, 11'd40);
    random_run(30, 12, 1'b0);

    drain();
    $display("Sent %0d page access requests, checked %0d results over capacities 0..2047",
             requests_sent, buf_model.results_seen);
    $display("and page widths 0..63 with random gaps and output stalls.");
    if (buf_model.mismatches == 0 && buf_model.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lsw_pkg.sv
rtl/lsw_front.sv
rtl/lsw_engine.sv
rtl/lru_sector_write_buffer_top.sv
dv/lru_sector_write_buffer_top_tb.sv
